// ===== rtl/bgf_pkg.sv =====
package bgf_pkg;

	// Configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DIM_W  = 13;

	// Default for the largest fill side
	localparam int MAX_DIM_DEF = 4096;

	// Color and fixed point
	localparam int CH_W       = 8;
	localparam int N_CH       = 4;
	localparam int CH_SEL_W   = 2;
	localparam int FRAC_W     = 16;
	localparam int ACC_W      = 25;
	localparam int STEP_DVD_W = CH_W + FRAC_W;
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32'h8000);

	// Input beat width
	localparam int IN_DATA_W = 8;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_LEFT     = 3'd0,
		REG_TOP_RIGHT    = 3'd1,
		REG_BOTTOM_LEFT  = 3'd2,
		REG_BOTTOM_RIGHT = 3'd3,
		REG_WIDTH        = 3'd4,
		REG_HEIGHT       = 3'd5,
		REG_FOUR_CH      = 3'd6
	} cfg_reg_t;

	// Which division of the row setup is running
	typedef enum logic [1:0] {
		PH_LEFT  = 2'd0,
		PH_RIGHT = 2'd1,
		PH_STEP  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_START = 2'd1,
		ST_WAIT  = 2'd2,
		ST_EMIT  = 2'd3
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic                clear_chans;
		logic                div_start;
		logic                store;
		logic                emit;
		phase_t              phase;
		logic [CH_SEL_W-1:0] chan;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic four_ch;
	} status_t;

endpackage

// ===== rtl/bgf_divider.sv =====
module bgf_divider import bgf_pkg::*; #(
	parameter int DVD_W = 24,
	parameter int DVS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// One restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift registers: dividend bits leave the top, quotient bits enter the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/bgf_datapath.sv =====
module bgf_datapath import bgf_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	// control
	input  cmd_t                          cmd,
	input  logic [$clog2(MAX_DIM)-1:0]    setup_row,
	output status_t                       status,
	output logic [$clog2(MAX_DIM+1)-1:0]  dim_w,
	output logic [$clog2(MAX_DIM+1)-1:0]  dim_h,
	// pixel
	output logic [N_CH*CH_W-1:0]          pixel
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int DVS_W = $clog2(MAX_DIM + 2);
	localparam int NUM_W = DVS_W + CH_W;
	localparam int DVD_W = (NUM_W > STEP_DVD_W) ? NUM_W : STEP_DVD_W;
	localparam int CMP_W = (CFG_DIM_W > DIM_W) ? CFG_DIM_W : DIM_W;

	// Configuration registers
	logic [CFG_DATA_W-1:0] tl_q, tr_q, bl_q, br_q;
	logic [CFG_DIM_W-1:0]  width_q, height_q;
	logic                  four_ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q      <= '0;
			tr_q      <= '0;
			bl_q      <= '0;
			br_q      <= '0;
			width_q   <= CFG_DIM_W'(1);
			height_q  <= CFG_DIM_W'(1);
			four_ch_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TOP_LEFT:     tl_q      <= cfg_data;
				REG_TOP_RIGHT:    tr_q      <= cfg_data;
				REG_BOTTOM_LEFT:  bl_q      <= cfg_data;
				REG_BOTTOM_RIGHT: br_q      <= cfg_data;
				REG_WIDTH:        width_q   <= cfg_data[CFG_DIM_W-1:0];
				REG_HEIGHT:       height_q  <= cfg_data[CFG_DIM_W-1:0];
				REG_FOUR_CH:      four_ch_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sizes clamped to 1..MAX_DIM
	always_comb begin
		if (width_q == '0)
			dim_w = DIM_W'(1);
		else if (CMP_W'(width_q) > CMP_W'(MAX_DIM))
			dim_w = DIM_W'(MAX_DIM);
		else
			dim_w = DIM_W'(width_q);
		if (height_q == '0)
			dim_h = DIM_W'(1);
		else if (CMP_W'(height_q) > CMP_W'(MAX_DIM))
			dim_h = DIM_W'(MAX_DIM);
		else
			dim_h = DIM_W'(height_q);
	end

	// Row setup operands
	logic [CH_W-1:0]     tl_b, tr_b, bl_b, br_b;
	logic [DIM_W-1:0]    top_wt, bot_wt;
	logic [NUM_W-1:0]    num_left, num_right;
	logic [CH_W-1:0]     left_q, right_q;
	logic [CH_W:0]       diff;
	logic                diff_neg;
	logic [CH_W-1:0]     diff_mag;
	logic [DVD_W-1:0]    dividend;
	logic [DVS_W-1:0]    divisor;
	logic [DVD_W-1:0]    quotient;
	logic                div_done;
	logic [ACC_W-1:0]    step_mag, step_val, acc_seed;

	always_comb begin
		tl_b      = tl_q[{cmd.chan, 3'b000} +: CH_W];
		tr_b      = tr_q[{cmd.chan, 3'b000} +: CH_W];
		bl_b      = bl_q[{cmd.chan, 3'b000} +: CH_W];
		br_b      = br_q[{cmd.chan, 3'b000} +: CH_W];
		top_wt    = dim_h - DIM_W'(setup_row);
		bot_wt    = DIM_W'(setup_row) + DIM_W'(1);
		num_left  = NUM_W'(top_wt) * NUM_W'(tl_b) + NUM_W'(bot_wt) * NUM_W'(bl_b);
		num_right = NUM_W'(top_wt) * NUM_W'(tr_b) + NUM_W'(bot_wt) * NUM_W'(br_b);
		diff      = {1'b0, right_q} - {1'b0, left_q};
		diff_neg  = diff[CH_W];
		diff_mag  = diff_neg ? CH_W'(-diff) : diff[CH_W-1:0];
		case (cmd.phase)
			PH_LEFT: begin
				dividend = DVD_W'(num_left);
				divisor  = DVS_W'(dim_h) + DVS_W'(1);
			end
			PH_RIGHT: begin
				dividend = DVD_W'(num_right);
				divisor  = DVS_W'(dim_h) + DVS_W'(1);
			end
			PH_STEP: begin
				dividend = DVD_W'({diff_mag, {FRAC_W{1'b0}}});
				divisor  = DVS_W'(dim_w) + DVS_W'(1);
			end
			default: begin
				dividend = '0;
				divisor  = DVS_W'(1);
			end
		endcase
		// signed 9.16 step, truncated toward zero
		step_mag = ACC_W'(quotient[STEP_DVD_W-1:0]);
		step_val = diff_neg ? -step_mag : step_mag;
		acc_seed = ACC_W'({left_q, {FRAC_W{1'b0}}}) + step_val + ROUND_HALF;
	end

	bgf_divider #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// Edge colors, steps, accumulators and pixel register
	logic [ACC_W-1:0]      acc_q  [N_CH];
	logic [ACC_W-1:0]      step_q [N_CH];
	logic [N_CH*CH_W-1:0]  pixel_q;

	always_ff @(posedge clk) begin
		if (cmd.store && cmd.phase == PH_LEFT)
			left_q <= quotient[CH_W-1:0];
		if (cmd.store && cmd.phase == PH_RIGHT)
			right_q <= quotient[CH_W-1:0];
		for (int k = 0; k < N_CH; k++) begin
			if (cmd.clear_chans) begin
				acc_q[k]  <= '0;
				step_q[k] <= '0;
			end else if (cmd.store && cmd.phase == PH_STEP && cmd.chan == CH_SEL_W'(k)) begin
				acc_q[k]  <= acc_seed;
				step_q[k] <= step_val;
			end else if (cmd.emit) begin
				acc_q[k] <= acc_q[k] + step_q[k];
			end
		end
		if (cmd.emit) begin
			for (int k = 0; k < N_CH - 1; k++)
				pixel_q[k*CH_W +: CH_W] <= acc_q[k][FRAC_W +: CH_W];
			pixel_q[(N_CH-1)*CH_W +: CH_W] <=
				four_ch_q ? acc_q[N_CH-1][FRAC_W +: CH_W] : '0;
		end
	end

	assign pixel           = pixel_q;
	assign status.div_done = div_done;
	assign status.four_ch  = four_ch_q;

endmodule

// ===== rtl/bgf_ctrl.sv =====
module bgf_ctrl import bgf_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beats
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_restart,
	// output beats
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_row_end,
	output logic                          out_fill_end,
	// datapath
	output cmd_t                          cmd,
	output logic [$clog2(MAX_DIM)-1:0]    setup_row,
	input  status_t                       status,
	input  logic [$clog2(MAX_DIM+1)-1:0]  dim_w,
	input  logic [$clog2(MAX_DIM+1)-1:0]  dim_h
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	state_t              state_q, state_d;
	phase_t              phase_q;
	logic [CH_SEL_W-1:0] chan_q;
	logic [IDX_W-1:0]    row_q, col_q, setup_row_q;
	logic                out_valid_q, row_end_q, fill_end_q;
	logic                pend_row_end_q, pend_fill_end_q;

	logic [IDX_W-1:0]    eff_row, eff_col;
	logic                need_setup, last_col, last_row, out_free, accept;
	logic [CH_SEL_W-1:0] last_chan;

	// Position of the item on offer
	always_comb begin
		eff_row    = in_restart ? '0 : row_q;
		eff_col    = in_restart ? '0 : col_q;
		need_setup = eff_col == '0;
		last_col   = (DIM_W'(eff_col) + DIM_W'(1)) >= dim_w;
		last_row   = (DIM_W'(eff_row) + DIM_W'(1)) >= dim_h;
		last_chan  = status.four_ch ? CH_SEL_W'(N_CH - 1) : CH_SEL_W'(N_CH - 2);
		out_free   = !out_valid_q || out_ready;
	end

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		accept          = 1'b0;
		cmd.clear_chans = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.store       = 1'b0;
		cmd.emit        = 1'b0;
		cmd.phase       = phase_q;
		cmd.chan        = chan_q;
		case (state_q)
			ST_RUN: begin
				in_ready = out_free;
				accept   = in_valid && out_free;
				if (accept) begin
					if (need_setup) begin
						cmd.clear_chans = 1'b1;
						state_d         = ST_START;
					end else begin
						cmd.emit = 1'b1;
					end
				end
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.div_done) begin
					cmd.store = 1'b1;
					if (phase_q == PH_STEP && chan_q == last_chan)
						state_d = ST_EMIT;
					else
						state_d = ST_START;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	// State, counters and setup sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			phase_q     <= PH_LEFT;
			chan_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				col_q <= last_col ? '0 : eff_col + IDX_W'(1);
				if (last_col)
					row_q <= last_row ? '0 : eff_row + IDX_W'(1);
				else
					row_q <= eff_row;
			end
			if (cmd.clear_chans) begin
				phase_q <= PH_LEFT;
				chan_q  <= '0;
			end else if (cmd.store) begin
				case (phase_q)
					PH_LEFT:  phase_q <= PH_RIGHT;
					PH_RIGHT: phase_q <= PH_STEP;
					default: begin
						phase_q <= PH_LEFT;
						chan_q  <= chan_q + CH_SEL_W'(1);
					end
				endcase
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Row and end flags held for the pending pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			setup_row_q     <= (DIM_W'(eff_row) >= dim_h) ?
				IDX_W'(dim_h - DIM_W'(1)) : eff_row;
			pend_row_end_q  <= last_col;
			pend_fill_end_q <= last_col && last_row;
		end
		if (cmd.emit) begin
			if (state_q == ST_RUN) begin
				row_end_q  <= last_col;
				fill_end_q <= last_col && last_row;
			end else begin
				row_end_q  <= pend_row_end_q;
				fill_end_q <= pend_fill_end_q;
			end
		end
	end

	assign setup_row    = setup_row_q;
	assign out_valid    = out_valid_q;
	assign out_row_end  = row_end_q;
	assign out_fill_end = fill_end_q;

endmodule

// ===== rtl/bilinear_gradient_fill.sv =====
// Bilinear gradient fill: streams one pixel per input beat, row by row.
// Slave beat: s_axis_tdata bit 0 = restart (1 starts a new fill at row 0,
// column 0). Master beat: pixel in m_axis_tdata (red, green, blue, alpha
// from bit 0 up), m_axis_tlast marks the last pixel of a row and
// m_axis_tuser[0] the last pixel of the fill. After the last pixel the next
// beat starts a new fill on its own.
// Registers are written through the cfg channel (always ready); the user
// must write them only while no beat is in flight, as the block does not
// enforce it. Indexes 0..3 are corners, 4 width, 5 height, 6 four-channel.
// Timing: a beat in the middle of a row gives its pixel in the cycle after
// acceptance, and a new beat is taken every cycle while m_axis_tready is
// high. A beat that starts a row runs the row setup on one shared bit-serial
// divider: three divisions per color channel (3 or 4 channels) in turn, then
// the pixel is loaded; no beat is taken while the setup runs.
// Reset clears the position to row 0, column 0, sizes to 1, colors to 0.
// While m_axis_tready is low the pixel is held and s_axis_tready stays low;
// a row setup already running finishes and its pixel waits until the
// register frees.
module bilinear_gradient_fill import bgf_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [0] restart, rest zero
	// output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [N_CH*CH_W-1:0]   m_axis_tdata,   // red, green, blue, alpha
	output logic                   m_axis_tlast,   // row_end
	output logic [0:0]             m_axis_tuser    // [0] fill_end
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	cmd_t              cmd;
	status_t           status;
	logic [IDX_W-1:0]  setup_row;
	logic [DIM_W-1:0]  dim_w, dim_h;
	logic              fill_end;

	assign cfg_ready = 1'b1;

	bgf_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_restart   (s_axis_tdata[0]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_row_end  (m_axis_tlast),
		.out_fill_end (fill_end),
		.cmd          (cmd),
		.setup_row    (setup_row),
		.status       (status),
		.dim_w        (dim_w),
		.dim_h        (dim_h)
	);

	bgf_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.setup_row (setup_row),
		.status    (status),
		.dim_w     (dim_w),
		.dim_h     (dim_h),
		.pixel     (m_axis_tdata)
	);

	assign m_axis_tuser[0] = fill_end;

endmodule
